### rtl/bzf_pkg.sv
// ============================================================================
// bzf_pkg
// Types, sequencer codes and step tables shared by the Bezier flattener.
// ============================================================================
`default_nettype none

package bzf_pkg;

    localparam int COORD_W   = 24;
    localparam int STEPS_W   = 6;
    localparam int T_W       = 17;
    localparam int WGT_W     = 33;
    localparam int ACC_W     = 57;
    localparam int REM_W     = 7;

    localparam logic [STEPS_W-1:0] MAX_STEPS = 6'd62;
    localparam logic [T_W:0]       T_ONE     = 18'h10000;
    localparam logic [WGT_W:0]     WGT_ONE   = 34'h1_0000_0000;

    // 65536 / n and 65536 % n for n = 0 .. 63 (unused codes hold zero)
    localparam logic [T_W-1:0] QUO_TAB [64] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107,
        17'd10922, 17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,
        17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096,  17'd3855,
        17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
        17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,
        17'd2184,  17'd2114,  17'd2048,  17'd1985,  17'd1927,  17'd1872,
        17'd1820,  17'd1771,  17'd1724,  17'd1680,  17'd1638,  17'd1598,
        17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,
        17'd1365,  17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,
        17'd1213,  17'd1191,  17'd1170,  17'd1149,  17'd1129,  17'd1110,
        17'd1092,  17'd1074,  17'd1057,  17'd0
    };

    localparam logic [STEPS_W-1:0] REM_TAB [64] = '{
        6'd0,  6'd0,  6'd0,  6'd1,  6'd0,  6'd1,  6'd4,  6'd2,
        6'd0,  6'd7,  6'd6,  6'd9,  6'd4,  6'd3,  6'd2,  6'd1,
        6'd0,  6'd1,  6'd16, 6'd5,  6'd16, 6'd16, 6'd20, 6'd9,
        6'd16, 6'd11, 6'd16, 6'd7,  6'd16, 6'd25, 6'd16, 6'd2,
        6'd0,  6'd31, 6'd18, 6'd16, 6'd16, 6'd9,  6'd24, 6'd16,
        6'd16, 6'd18, 6'd16, 6'd4,  6'd20, 6'd16, 6'd32, 6'd18,
        6'd16, 6'd23, 6'd36, 6'd1,  6'd16, 6'd28, 6'd34, 6'd31,
        6'd16, 6'd43, 6'd54, 6'd46, 6'd16, 6'd22, 6'd2,  6'd0
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_LAST
    } state_t;

    typedef enum logic [3:0] {
        PH_ADV,
        PH_TT,
        PH_UU,
        PH_WGT,
        PH_AX1,
        PH_BX2,
        PH_CX3,
        PH_AY1,
        PH_BY2,
        PH_CY3,
        PH_SUMY,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic init;
        logic advance;
    } tg_ctl_t;

    typedef struct packed {
        logic   load;
        phase_t phase;
    } dp_ctl_t;

endpackage

`default_nettype wire

### rtl/quadratic_bezier_flattener.sv
// ============================================================================
// quadratic_bezier_flattener
// Breaks one quadratic Bezier curve into steps+2 points, rounded Q15.8.
// ============================================================================
//
//   channel  dir  handshake                  payload
//   -------  ---  -------------------------  ---------------------------------
//   curve    in   curve_valid / curve_stall  start_*, ctrl_*, end_*, steps
//   point    out  point_valid / point_stall  point_x, point_y, is_start, last
//
// A curve yields steps+2 beats; steps above 62 count as 62. The start point
// leaves the cycle after the curve is taken, each interpolated point runs
// through the shared multiplier sequence (t step, two squares, six weighted
// products), and the end point follows the last interpolated point.
// curve_stall stays high until the last beat has left the output register.
// A stall on the point side freezes the sequencer at its final phase. Reset
// clears the sequencer and output valid.
`default_nettype none

module quadratic_bezier_flattener (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                curve_valid,
    output logic                                     curve_stall,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  ctrl_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  ctrl_y,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  end_y,
    input  wire logic        [bzf_pkg::STEPS_W-1:0]  steps,
    output logic                                     point_valid,
    input  wire logic                                point_stall,
    output logic signed      [bzf_pkg::COORD_W-1:0]  point_x,
    output logic signed      [bzf_pkg::COORD_W-1:0]  point_y,
    output logic                                     is_start,
    output logic                                     last
);
    import bzf_pkg::*;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [STEPS_W-1:0]   k_reg, k_next;
    logic                 valid_reg, valid_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic                 start_reg, start_next, last_reg, last_next;

    tg_ctl_t              tg_ctl;
    dp_ctl_t              dp_ctl;
    logic [STEPS_W-1:0]   steps_n;
    logic [STEPS_W-1:0]   n;
    logic [T_W-1:0]       t, u;
    logic signed [COORD_W-1:0] p3_x, p3_y, res_x, res_y;
    logic                 out_free;
    logic                 accept;

    assign steps_n     = (steps > MAX_STEPS) ? MAX_STEPS : steps;
    assign curve_stall = (state_reg != S_IDLE) || valid_reg;
    assign accept      = curve_valid && !curve_stall;
    assign out_free    = !valid_reg || !point_stall;

    bzf_tgen u_tgen (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tg_ctl),
        .steps_n (steps_n),
        .n       (n),
        .t       (t),
        .u       (u)
    );

    bzf_datapath u_dp (
        .clk     (clk),
        .ctl     (dp_ctl),
        .start_x (start_x),
        .start_y (start_y),
        .ctrl_x  (ctrl_x),
        .ctrl_y  (ctrl_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .t       (t),
        .u       (u),
        .p3_x    (p3_x),
        .p3_y    (p3_y),
        .res_x   (res_x),
        .res_y   (res_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        valid_next     = valid_reg && point_stall;
        px_next        = px_reg;
        py_next        = py_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        tg_ctl.init    = 1'b0;
        tg_ctl.advance = 1'b0;
        dp_ctl.load    = 1'b0;
        dp_ctl.phase   = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tg_ctl.init = 1'b1;
                    dp_ctl.load = 1'b1;
                    valid_next  = 1'b1;
                    px_next     = start_x;
                    py_next     = start_y;
                    start_next  = 1'b1;
                    last_next   = 1'b0;
                    k_next      = STEPS_W'(1);
                    phase_next  = PH_ADV;
                    state_next  = (steps_n == '0) ? S_LAST : S_CALC;
                end
            end
            S_CALC:
            begin
                if (phase_reg == PH_ADV)
                begin
                    tg_ctl.advance = 1'b1;
                end
                if (phase_reg == PH_DONE)
                begin
                    if (out_free)
                    begin
                        valid_next = 1'b1;
                        px_next    = res_x;
                        py_next    = res_y;
                        start_next = 1'b0;
                        last_next  = 1'b0;
                        phase_next = PH_ADV;
                        if (k_reg == n)
                        begin
                            state_next = S_LAST;
                        end
                        else
                        begin
                            k_next = k_reg + STEPS_W'(1);
                        end
                    end
                end
                else
                begin
                    phase_next = phase_t'(4'(phase_reg) + 4'd1);
                end
            end
            S_LAST:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    px_next    = p3_x;
                    py_next    = p3_y;
                    start_next = 1'b0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_ADV;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        start_reg <= start_next;
        last_reg  <= last_next;
    end

    assign point_valid = valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign is_start    = start_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

### rtl/bzf_tgen.sv
// ============================================================================
// bzf_tgen
// Curve parameter generator: t = round(k / steps) in Q1.16, stepped in k.
// ============================================================================
`default_nettype none

module bzf_tgen (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bzf_pkg::tg_ctl_t             ctl,
    input  wire logic [bzf_pkg::STEPS_W-1:0]  steps_n,
    output logic      [bzf_pkg::STEPS_W-1:0]  n,
    output logic      [bzf_pkg::T_W-1:0]      t,
    output logic      [bzf_pkg::T_W-1:0]      u
);
    import bzf_pkg::*;

    logic [STEPS_W-1:0] n_reg, n_next;
    logic [T_W-1:0]     q_reg, q_next;
    logic [REM_W-1:0]   r_reg, r_next;
    logic [REM_W-1:0]   r_sum;
    logic [T_W-1:0]     q_sum;

    // numerator grows by 65536 per step, remainder kept below n
    assign r_sum = r_reg + REM_W'(REM_TAB[n_reg]);
    assign q_sum = q_reg + QUO_TAB[n_reg];

    always_comb
    begin
        n_next = n_reg;
        q_next = q_reg;
        r_next = r_reg;
        if (ctl.init)
        begin
            n_next = steps_n;
            q_next = '0;
            r_next = REM_W'(steps_n >> 1);
        end
        else if (ctl.advance)
        begin
            if (r_sum >= REM_W'(n_reg))
            begin
                r_next = r_sum - REM_W'(n_reg);
                q_next = q_sum + T_W'(1);
            end
            else
            begin
                r_next = r_sum;
                q_next = q_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
        end
        else
        begin
            n_reg <= n_next;
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign n = n_reg;
    assign t = q_reg;
    assign u = T_W'(T_ONE - (T_W + 1)'(q_reg));

endmodule

`default_nettype wire

### rtl/bzf_datapath.sv
// ============================================================================
// bzf_datapath
// Shared multiplier with product register, weight registers and accumulator.
// ============================================================================
`default_nettype none

module bzf_datapath (
    input  wire logic                                clk,
    input  wire bzf_pkg::dp_ctl_t                    ctl,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  ctrl_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  ctrl_y,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  end_y,
    input  wire logic        [bzf_pkg::T_W-1:0]      t,
    input  wire logic        [bzf_pkg::T_W-1:0]      u,
    output logic signed      [bzf_pkg::COORD_W-1:0]  p3_x,
    output logic signed      [bzf_pkg::COORD_W-1:0]  p3_y,
    output logic signed      [bzf_pkg::COORD_W-1:0]  res_x,
    output logic signed      [bzf_pkg::COORD_W-1:0]  res_y
);
    import bzf_pkg::*;

    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic        [WGT_W-1:0]   wa_reg, wb_reg, wc_reg;
    logic signed [ACC_W-1:0]   prod_reg, acc_reg, rx_reg;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [WGT_W:0]     mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [ACC_W:0]     mul_p;

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctl.phase)
            PH_TT:
            begin
                mul_a = $signed((WGT_W + 1)'(t));
                mul_b = $signed(COORD_W'(t));
            end
            PH_UU:
            begin
                mul_a = $signed((WGT_W + 1)'(u));
                mul_b = $signed(COORD_W'(u));
            end
            PH_AX1:
            begin
                mul_a = $signed((WGT_W + 1)'(wa_reg));
                mul_b = x1_reg;
            end
            PH_BX2:
            begin
                mul_a = $signed((WGT_W + 1)'(wb_reg));
                mul_b = x2_reg;
            end
            PH_CX3:
            begin
                mul_a = $signed((WGT_W + 1)'(wc_reg));
                mul_b = x3_reg;
            end
            PH_AY1:
            begin
                mul_a = $signed((WGT_W + 1)'(wa_reg));
                mul_b = y1_reg;
            end
            PH_BY2:
            begin
                mul_a = $signed((WGT_W + 1)'(wb_reg));
                mul_b = y2_reg;
            end
            PH_CY3:
            begin
                mul_a = $signed((WGT_W + 1)'(wc_reg));
                mul_b = y3_reg;
            end
            default:
            begin
                mul_a = $signed((WGT_W + 1)'(wa_reg));
                mul_b = x1_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x1_reg <= start_x;
            y1_reg <= start_y;
            x2_reg <= ctrl_x;
            y2_reg <= ctrl_y;
            x3_reg <= end_x;
            y3_reg <= end_y;
        end
        prod_reg <= mul_p[ACC_W-1:0];
        case (ctl.phase)
            PH_UU:
            begin
                wc_reg <= prod_reg[WGT_W-1:0];
            end
            PH_WGT:
            begin
                // weights sum to one, so the middle one needs no multiply
                wa_reg <= prod_reg[WGT_W-1:0];
                wb_reg <= WGT_W'(WGT_ONE - (WGT_W + 1)'(prod_reg[WGT_W-1:0])
                                         - (WGT_W + 1)'(wc_reg));
            end
            PH_BX2:
            begin
                acc_reg <= prod_reg;
            end
            PH_CX3, PH_AY1, PH_CY3, PH_SUMY:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            PH_BY2:
            begin
                rx_reg  <= acc_rnd;
                acc_reg <= prod_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // round half up, drop the 32 weight fraction bits
    assign acc_rnd = acc_reg + ACC_W'(64'h8000_0000);

    assign p3_x  = x3_reg;
    assign p3_y  = y3_reg;
    assign res_x = rx_reg[55:32];
    assign res_y = acc_rnd[55:32];

endmodule

`default_nettype wire

### rtl/bzf_checker.sv
// ============================================================================
// bzf_checker
// Port-level checks on the Bezier flattener beat sequence.
// ============================================================================
`default_nettype none

module bzf_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                curve_valid,
    input  wire logic                                curve_stall,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  start_y,
    input  wire logic                                point_valid,
    input  wire logic                                point_stall,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  point_x,
    input  wire logic signed [bzf_pkg::COORD_W-1:0]  point_y,
    input  wire logic                                is_start,
    input  wire logic                                last
);

    // a taken curve shows its start point on the next cycle
    a_start_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (curve_valid && !curve_stall) |=>
            (point_valid && is_start && !last
             && point_x == $past(start_x) && point_y == $past(start_y)))
        else $error("start beat missing after curve beat");

    // no new curve while a point is still pending
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> curve_stall)
        else $error("curve taken while point pending");

    // after the closing beat leaves, the output goes quiet
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && last && !point_stall) |=> !point_valid)
        else $error("beat after end of curve");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_stall) |=>
            (point_valid && $stable(point_x) && $stable(point_y)
             && $stable(is_start) && $stable(last)))
        else $error("stalled point beat changed");

endmodule

bind quadratic_bezier_flattener bzf_checker u_bzf_checker (.*);

`default_nettype wire
